@@ src/bcc_pkg.sv @@
// ---------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants for the button click classifier.
// ---------------------------------------------------------------------------
package bcc_pkg;

  // Default number of keys, and how many have a level bit, enable bit and
  // result field.
  localparam int NUM_KEYS_DEF = 3;
  localparam int OUT_KEYS     = 3;

  localparam int TICK_W  = 32;
  localparam int TIME_W  = 16;
  localparam int EVENT_W = 3;
  localparam int COUNT_W = 3;

  localparam int IN_TDATA_W  = 40;  // 35 payload bits padded to whole bytes
  localparam int OUT_TDATA_W = 16;  // 9 payload bits padded to whole bytes
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLICK_GAP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EVENT_MASK = 2'd2;

  localparam logic [TIME_W-1:0] LONG_PRESS_RST = 16'd1500;
  localparam logic [TIME_W-1:0] CLICK_GAP_RST  = 16'd200;

  // Event codes.
  localparam logic [EVENT_W-1:0] EV_NONE   = 3'd0;
  localparam logic [EVENT_W-1:0] EV_SINGLE = 3'd1;
  localparam logic [EVENT_W-1:0] EV_DOUBLE = 3'd2;
  localparam logic [EVENT_W-1:0] EV_TRIPLE = 3'd3;
  localparam logic [EVENT_W-1:0] EV_LONG   = 3'd4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 3'd7;

  typedef struct packed {
    logic [TIME_W-1:0] long_press_ms;
    logic [TIME_W-1:0] click_gap_ms;
  } timing_t;

endpackage

@@ src/button_click_classifier.sv @@
// ---------------------------------------------------------------------------
// button_click_classifier
// Multi-click and long-press detector for a set of active-low keys.
//
//   channel   dir  handshake                       payload (lowest bit up)
//   s_axis    in   s_axis_tvalid / s_axis_tready   now_ticks[31:0], key_levels[34:32]
//   m_axis    out  m_axis_tvalid / m_axis_tready   key0_event, key1_event, key2_event
//   cfg       in   cfg_we                          cfg_index, cfg_data
//
// One scan per cycle. Each lane does one 32-bit subtract and compare, and the
// result is registered as the request is accepted. A new request is taken
// whenever the output register is empty or being drained. Reset is
// synchronous and restores the default timings, a zero mask and released keys.
// ---------------------------------------------------------------------------
module button_click_classifier #(
  parameter int NUM_KEYS = bcc_pkg::NUM_KEYS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // now_ticks[31:0], key_levels[34:32], zero padding
  input  logic [bcc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // key0_event[2:0], key1_event[5:3], key2_event[8:6], zero padding
  output logic [bcc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                             cfg_we,
  input  logic [bcc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bcc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bcc_pkg::*;

  timing_t                     timing;
  logic [OUT_KEYS-1:0]         event_enable_mask;
  logic                        scan_fire;
  logic [TICK_W-1:0]           now_ticks;
  logic [OUT_KEYS-1:0]         key_levels;
  logic [NUM_KEYS*EVENT_W-1:0] lane_events;

  assign now_ticks     = s_axis_tdata[TICK_W-1:0];
  assign key_levels    = s_axis_tdata[TICK_W +: OUT_KEYS];
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign scan_fire     = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      timing.long_press_ms <= LONG_PRESS_RST;
      timing.click_gap_ms  <= CLICK_GAP_RST;
      event_enable_mask    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LONG_PRESS: timing.long_press_ms <= cfg_data[TIME_W-1:0];
        REG_CLICK_GAP:  timing.click_gap_ms  <= cfg_data[TIME_W-1:0];
        REG_EVENT_MASK: event_enable_mask    <= cfg_data[OUT_KEYS-1:0];
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic level;
    // Keys past the level field have no input and always read released.
    if (k < OUT_KEYS) begin : g_wired
      assign level = key_levels[k];
    end else begin : g_unwired
      assign level = 1'b1;
    end

    bcc_key_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .scan_fire (scan_fire),
      .now_ticks (now_ticks),
      .level     (level),
      .timing    (timing),
      .key_event (lane_events[k*EVENT_W +: EVENT_W])
    );
  end

  bcc_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk               (clk),
    .rst               (rst),
    .scan_fire         (scan_fire),
    .lane_events       (lane_events),
    .event_enable_mask (event_enable_mask),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tdata      (m_axis_tdata)
  );

endmodule

@@ src/bcc_key_lane.sv @@
// ---------------------------------------------------------------------------
// bcc_key_lane
// Per-key state and classification for one key of a scan.
// ---------------------------------------------------------------------------
module bcc_key_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          scan_fire,
  input  logic [bcc_pkg::TICK_W-1:0]    now_ticks,
  input  logic                          level,
  input  bcc_pkg::timing_t              timing,
  output logic [bcc_pkg::EVENT_W-1:0]   key_event
);
  import bcc_pkg::*;

  logic               prev_level;
  logic [TICK_W-1:0]  press_stamp;
  logic [TICK_W-1:0]  release_stamp;
  logic               long_armed;
  logic [COUNT_W-1:0] press_count;

  logic               fall;
  logic               held;
  logic               rise;
  logic               idle;
  logic [TICK_W-1:0]  stamp;
  logic [TIME_W-1:0]  limit;
  logic [TICK_W-1:0]  elapsed;
  logic               due;
  logic               long_hit;
  logic               gap_hit;

  assign fall = !level &&  prev_level;
  assign held = !level && !prev_level;
  assign rise =  level && !prev_level;
  assign idle =  level &&  prev_level;

  // A held key measures from its press, a released key from its release, so
  // one subtract and compare serves both.
  assign stamp   = level ? release_stamp : press_stamp;
  assign limit   = level ? timing.click_gap_ms : timing.long_press_ms;
  assign elapsed = now_ticks - stamp;
  assign due     = elapsed >= {{(TICK_W-TIME_W){1'b0}}, limit};

  assign long_hit = held && due && long_armed;
  assign gap_hit  = idle && due && (press_count != '0);

  always_comb begin
    key_event = EV_NONE;
    if (long_hit) begin
      key_event = EV_LONG;
    end else if (gap_hit && press_count <= COUNT_W'(EV_TRIPLE)) begin
      key_event = EVENT_W'(press_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level    <= 1'b1;
      press_stamp   <= '0;
      release_stamp <= '0;
      long_armed    <= 1'b0;
      press_count   <= '0;
    end else if (scan_fire) begin
      prev_level <= level;
      if (fall) begin
        press_stamp <= now_ticks;
        long_armed  <= 1'b1;
        if (press_count != COUNT_MAX) begin
          press_count <= press_count + 1'b1;
        end
      end
      if (rise) begin
        release_stamp <= now_ticks;
      end
      if (long_hit) begin
        long_armed  <= 1'b0;
        press_count <= '0;
      end
      // Four or more presses end here too, silently.
      if (gap_hit) begin
        press_count <= '0;
      end
    end
  end

endmodule

@@ src/bcc_merge.sv @@
// ---------------------------------------------------------------------------
// bcc_merge
// Masks the lane events and holds the result in the output register.
// ---------------------------------------------------------------------------
module bcc_merge #(
  parameter int NUM_KEYS = bcc_pkg::NUM_KEYS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             scan_fire,
  input  logic [NUM_KEYS*bcc_pkg::EVENT_W-1:0] lane_events,
  input  logic [bcc_pkg::OUT_KEYS-1:0]     event_enable_mask,
  input  logic                             m_axis_tready,
  output logic                             m_axis_tvalid,
  output logic [bcc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import bcc_pkg::*;

  logic [OUT_KEYS*EVENT_W-1:0] merged;

  for (genvar k = 0; k < OUT_KEYS; k++) begin : g_field
    if (k < NUM_KEYS) begin : g_live
      assign merged[k*EVENT_W +: EVENT_W] =
        event_enable_mask[k] ? lane_events[k*EVENT_W +: EVENT_W] : EV_NONE;
    end else begin : g_absent
      assign merged[k*EVENT_W +: EVENT_W] = EV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (scan_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_fire) begin
      m_axis_tdata <= {{(OUT_TDATA_W-OUT_KEYS*EVENT_W){1'b0}}, merged};
    end
  end

endmodule

@@ verif/tb_button_click_classifier.sv @@
// ---------------------------------------------------------------------------
// tb_button_click_classifier
// Self-checking bench for the key click and long-press classifier. A table of
// directed scans walks the click codes, the long press, the disabled-key and
// zero-timing cases and tick wrap. Random scan streams then follow under
// several timing and mask settings. Every result is checked field by field
// against an event predictor kept in step with each accepted request.
// ---------------------------------------------------------------------------
module tb_button_click_classifier;
  import bcc_pkg::*;

  typedef logic [OUT_KEYS-1:0][EVENT_W-1:0] key_events_t;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] value;
    logic [TICK_W-1:0]     now;
    logic [OUT_KEYS-1:0]   levels;
    bit                    typed;
    key_events_t           events;
  } scan_row_t;

  localparam int HOLD_CYCLES = 200;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Event predictor: timing copy and per-key state.
  logic [TIME_W-1:0]   hold_limit;
  logic [TIME_W-1:0]   gap_limit;
  logic [OUT_KEYS-1:0] report_mask;
  logic                was_up     [NUM_KEYS_DEF];
  logic [TICK_W-1:0]   down_at    [NUM_KEYS_DEF];
  logic [TICK_W-1:0]   up_at      [NUM_KEYS_DEF];
  logic                long_ready [NUM_KEYS_DEF];
  logic [COUNT_W-1:0]  taps       [NUM_KEYS_DEF];

  key_events_t   pending_events[$];
  scan_row_t     scan_table[$];
  int            mismatches = 0;
  bit            idling_on  = 1'b1;
  bit            gaps_on    = 1'b1;
  bit            hold_req   = 1'b0;
  bit            hold_done  = 1'b0;
  logic [TICK_W-1:0] tick;

  button_click_classifier DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("button_click_classifier: mismatch");
    $finish;
  end

  function automatic void reset_predictor();
    hold_limit  = LONG_PRESS_RST;
    gap_limit   = CLICK_GAP_RST;
    report_mask = '0;
    for (int k = 0; k < NUM_KEYS_DEF; k++) begin
      was_up[k]     = 1'b1;
      down_at[k]    = '0;
      up_at[k]      = '0;
      long_ready[k] = 1'b0;
      taps[k]       = '0;
    end
  endfunction

  function automatic key_events_t classify_scan(input logic [TICK_W-1:0] now,
                                                input logic [OUT_KEYS-1:0] levels);
    key_events_t        res;
    logic [EVENT_W-1:0] ev;
    logic [TICK_W-1:0]  elapsed;
    res = '0;
    for (int k = 0; k < NUM_KEYS_DEF; k++) begin
      ev = EV_NONE;
      if (!levels[k] && was_up[k]) begin
        down_at[k]    = now;
        long_ready[k] = 1'b1;
        if (taps[k] != COUNT_MAX) taps[k] = taps[k] + 1'b1;
      end else if (!levels[k]) begin
        elapsed = now - down_at[k];
        if (elapsed >= hold_limit && long_ready[k]) begin
          long_ready[k] = 1'b0;
          taps[k]       = '0;
          ev            = EV_LONG;
        end
      end else if (!was_up[k]) begin
        up_at[k] = now;
      end else begin
        elapsed = now - up_at[k];
        if (elapsed >= gap_limit && taps[k] != '0) begin
          // One to three taps map straight onto the click codes.
          if (taps[k] <= EV_TRIPLE) ev = taps[k];
          taps[k] = '0;
        end
      end
      was_up[k] = levels[k];
      if (report_mask[k]) res[k] = ev;
    end
    return res;
  endfunction

  function automatic void flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR: %s", msg);
  endfunction

  function automatic void add_scan(input logic [TICK_W-1:0] now,
                                   input logic [OUT_KEYS-1:0] levels);
    scan_row_t r;
    r = '{default: '0};
    r.now    = now;
    r.levels = levels;
    scan_table.push_back(r);
  endfunction

  function automatic void add_typed(input logic [TICK_W-1:0] now,
                                    input logic [OUT_KEYS-1:0] levels, input key_events_t events);
    scan_row_t r;
    r = '{default: '0};
    r.now    = now;
    r.levels = levels;
    r.typed  = 1'b1;
    r.events = events;
    scan_table.push_back(r);
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
    scan_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.value  = value;
    scan_table.push_back(r);
  endfunction

  task automatic send_scan(input logic [TICK_W-1:0] now, input logic [OUT_KEYS-1:0] levels,
                           input bit typed, input key_events_t typed_events);
    key_events_t ev;
    if (gaps_on && idling_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({levels, now});
    do @(posedge clk); while (!s_axis_tready);
    ev = classify_scan(now, levels);
    if (typed) ev = typed_events;
    pending_events.push_back(ev);
  endtask

  // Stop offering requests and wait until every result has come back.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_LONG_PRESS: hold_limit  = value;
      REG_CLICK_GAP:  gap_limit   = value;
      REG_EVENT_MASK: report_mask = value[OUT_KEYS-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int hold_ms, input int gap_ms, input int mask);
    settle();
    write_reg(REG_LONG_PRESS, CFG_DATA_W'(hold_ms));
    write_reg(REG_CLICK_GAP, CFG_DATA_W'(gap_ms));
    write_reg(REG_EVENT_MASK, CFG_DATA_W'(mask));
  endtask

  // Random scans: keys toggle now and then, ticks mostly advance on the scale of
  // the current timings, with the odd jump anywhere in the tick range.
  task automatic run_phase(input int n_items, input bit with_hold);
    logic [TICK_W-1:0]   span;
    logic [OUT_KEYS-1:0] levels;
    span   = TICK_W'((hold_limit > gap_limit) ? hold_limit : gap_limit);
    levels = '1;
    for (int i = 0; i < n_items; i++) begin
      if (with_hold && i == 10) hold_req = 1'b1;
      gaps_on = !(with_hold && i >= 10 && i < 40);
      case ($urandom_range(0, 15))
        0:       tick = $urandom();
        1, 2:    tick = tick + $urandom_range(0, 2 * span + 2);
        default: tick = tick + $urandom_range(0, span / 4 + 1);
      endcase
      if ($urandom_range(0, 15) == 0) levels = OUT_KEYS'($urandom_range(0, 7));
      else levels = levels ^ OUT_KEYS'($urandom_range(0, 7) & $urandom_range(0, 7));
      send_scan(tick, levels, 1'b0, '0);
    end
    gaps_on = 1'b1;
  endtask

  // Output side: random stall bursts, plus one long hold-off on request.
  initial begin
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    key_events_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_events.size() == 0) begin
        flag_error($sformatf("unexpected result tdata=%h", m_axis_tdata));
      end else begin
        want = pending_events.pop_front();
        for (int k = 0; k < OUT_KEYS; k++) begin
          if (m_axis_tdata[k*EVENT_W +: EVENT_W] !== want[k])
            flag_error($sformatf("key%0d event: expected %0d, got %0d", k, want[k],
                                 m_axis_tdata[k*EVENT_W +: EVENT_W]));
        end
      end
    end
  end

  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    tick          = 32'hFFFF_FF00;
    reset_predictor();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The mask is still zero at first, so the long press on the
    // wrapped tick changes state but reports nothing.
    add_typed(32'h0000_0000, 3'b111, '0);
    add_typed(32'hFFFF_FFFF, 3'b000, '0);
    add_typed(32'd1499, 3'b000, '0);
    add_cfg(REG_EVENT_MASK, 16'h0007);
    add_scan(32'd1509, 3'b000);
    add_scan(32'd1510, 3'b111);
    add_scan(32'd1709, 3'b111);
    // Key 0 clicks once, key 1 twice, key 2 three times.
    add_scan(32'd2000, 3'b000);
    add_scan(32'd2010, 3'b111);
    add_scan(32'd2020, 3'b001);
    add_scan(32'd2030, 3'b111);
    add_scan(32'd2040, 3'b011);
    add_scan(32'd2050, 3'b111);
    add_typed(32'd2250, 3'b111, {EV_TRIPLE, EV_DOUBLE, EV_SINGLE});
    // Zero timings: key 1 long-presses on its first held scan, while key 0
    // taps four times and is then cleared without an event.
    add_cfg(REG_LONG_PRESS, 16'h0000);
    add_cfg(REG_CLICK_GAP, 16'h0000);
    add_scan(32'd3000, 3'b100);
    add_typed(32'd3001, 3'b101, {EV_NONE, EV_LONG, EV_NONE});
    add_scan(32'd3002, 3'b100);
    add_scan(32'd3003, 3'b101);
    add_scan(32'd3004, 3'b100);
    add_scan(32'd3005, 3'b101);
    add_scan(32'd3006, 3'b100);
    add_scan(32'd3007, 3'b111);
    add_typed(32'd3008, 3'b111, '0);

    foreach (scan_table[i]) begin
      if (scan_table[i].is_cfg) begin
        settle();
        write_reg(scan_table[i].idx, scan_table[i].value);
      end else begin
        send_scan(scan_table[i].now, scan_table[i].levels, scan_table[i].typed,
                  scan_table[i].events);
      end
    end

    // Random part.
    configure(20, 8, 7);
    run_phase(70, 1'b1);
    configure(1, 1, 5);
    run_phase(60, 1'b0);
    configure(65535, 65535, 7);
    run_phase(60, 1'b0);
    configure(40, 60, 2);
    run_phase(60, 1'b0);
    configure($urandom_range(2, 80), $urandom_range(2, 80), 0);
    run_phase(40, 1'b0);
    repeat (3) begin
      configure($urandom_range(2, 80), $urandom_range(2, 80), $urandom_range(1, 7));
      run_phase(60, 1'b0);
    end
    configure(25, 10, 7);
    idling_on = 1'b0;
    run_phase(80, 1'b0);

    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("button_click_classifier: match");
    end else begin
      $display("button_click_classifier: mismatch");
    end
    $finish;
  end

endmodule
